// ----- design/rwhp_pkg.sv -----
`default_nettype none

package rwhp_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666d_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam int unsigned MIN_FILE    = 44;
  localparam int unsigned FMT_MIN     = 16;
  localparam int unsigned FIRST_CHUNK = 12;
  localparam int unsigned TAG_BYTES   = 4;
  localparam int unsigned HDR_BYTES   = 8;

  localparam int unsigned RESULT_BITS = 168;

  typedef struct packed {
    logic        is_valid;
    logic [15:0] format_tag;
    logic [15:0] channel_count;
    logic [31:0] sample_freq;
    logic [31:0] bytes_per_sec;
    logic [15:0] frame_size;
    logic [15:0] sample_bits;
    logic [18:0] data_offset;
    logic [18:0] data_length;
  } result_t;

endpackage

`default_nettype wire

// ----- design/riff_wave_header_parser_top.sv -----
// WAV header parser.
// Input stream: one file byte per request on s_tdata[7:0], s_tlast on the
// final byte of the file. The RIFF/WAVE tags are checked and the chunk list
// is walked; the last complete fmt and data chunks are kept.
// Output stream: one request per file, issued for the byte that carries
// s_tlast. m_tuser holds the valid flag, m_tdata the format fields and the
// data chunk offset and length.
// Throughput: one byte per cycle while s_tready is high. The result is
// registered into the output register, or into the spare register while the
// output stalls; the parse step is a counter, a shift register and tag
// compares between the state registers and the result register.
// A spare result register sits behind the output register, so the next
// file keeps streaming while a result waits; s_tready drops only when both
// hold a result.
// Reset clears the parser state and the valid flags of both result registers;
// after each final byte the parser returns to its reset state on its own.
`default_nettype none

module riff_wave_header_parser_top #(
  parameter int unsigned MAX_FILE_BYTES = 262144
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_tvalid,
  output logic         s_tready,
  input  wire  [7:0]   s_tdata,   // file_byte
  input  wire          s_tlast,   // last_byte
  output logic         m_tvalid,
  input  wire          m_tready,
  // format_tag, channel_count, sample_freq, bytes_per_sec, frame_size,
  // sample_bits, data_offset, data_length, zero fill
  output logic [rwhp_pkg::RESULT_BITS-1:0] m_tdata,
  output logic         m_tuser    // is_valid
);

  logic              accept;
  logic              res_valid;
  rwhp_pkg::result_t res;
  rwhp_pkg::result_t out_res;
  rwhp_pkg::result_t spare_res;
  logic              spare_valid;
  logic              out_free;

  assign s_tready = !spare_valid;
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  rwhp_parse #(
    .MAX_FILE_BYTES(MAX_FILE_BYTES)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .file_byte (s_tdata),
    .last_byte (s_tlast),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid    <= 1'b0;
      spare_valid <= 1'b0;
    end else if (spare_valid && out_free) begin
      m_tvalid    <= 1'b1;
      spare_valid <= 1'b0;
    end else if (res_valid) begin
      if (out_free) begin
        m_tvalid <= 1'b1;
      end else begin
        spare_valid <= 1'b1;
      end
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (spare_valid && out_free) begin
      out_res <= spare_res;
    end else if (res_valid) begin
      if (out_free) begin
        out_res <= res;
      end else begin
        spare_res <= res;
      end
    end
  end

  assign m_tuser = out_res.is_valid;
  assign m_tdata = {2'b00, out_res.data_length, out_res.data_offset, out_res.sample_bits,
                    out_res.frame_size, out_res.bytes_per_sec, out_res.sample_freq,
                    out_res.channel_count, out_res.format_tag};

  a_spare_behind_out: assert property (@(posedge clk) disable iff (rst)
    spare_valid |-> m_tvalid)
    else $error("spare result held with empty output register");

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast && !m_tvalid) |=> m_tvalid)
    else $error("final byte produced no result");

  a_valid_has_data: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[165:147] != 19'd0))
    else $error("valid result with empty data chunk");

  a_spare_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (spare_valid && !m_tready) |=> spare_valid && !s_tready)
    else $error("spare result lost while output stalled");

endmodule

`default_nettype wire

// ----- design/rwhp_parse.sv -----
`default_nettype none

module rwhp_parse #(
  parameter int unsigned MAX_FILE_BYTES = 262144
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   accept,
  input  wire  [7:0]            file_byte,
  input  wire                   last_byte,
  output logic                  res_valid,
  output rwhp_pkg::result_t     res
);

  localparam int unsigned POS_W = $clog2(MAX_FILE_BYTES + 1);

  localparam logic [1:0] PH_FILE = 2'd0;
  localparam logic [1:0] PH_HDR  = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;
  localparam logic [1:0] PH_PAD  = 2'd3;

  logic [POS_W-1:0] pos, pos_next;
  logic             tags_ok, tags_ok_next;
  logic [1:0]       phase, phase_next;
  logic [31:0]      tag, tag_next;
  logic [31:0]      size, size_next;
  logic [31:0]      left, left_next;
  logic [18:0]      body_start, body_start_next;
  logic [4:0]       fmt_cnt, fmt_cnt_next;
  logic [7:0]       pending [16];
  logic [7:0]       pend_view [16];
  logic             pend_we;
  logic [31:0]      kept_fmt0, kept_fmt0_next;
  logic [31:0]      kept_fmt1, kept_fmt1_next;
  logic [63:0]      kept_rates, kept_rates_next;
  logic [18:0]      kept_doff, kept_doff_next;
  logic [18:0]      kept_dlen, kept_dlen_next;
  logic             ovf, ovf_next;
  logic             finish;
  logic             ok;
  logic [31:0]      pos_inc;

  assign pos_inc = 32'(pos) + 32'd1;

  always_comb begin
    pos_next        = pos;
    tags_ok_next    = tags_ok;
    phase_next      = phase;
    tag_next        = tag;
    size_next       = size;
    left_next       = left;
    body_start_next = body_start;
    fmt_cnt_next    = fmt_cnt;
    kept_fmt0_next  = kept_fmt0;
    kept_fmt1_next  = kept_fmt1;
    kept_rates_next = kept_rates;
    kept_doff_next  = kept_doff;
    kept_dlen_next  = kept_dlen;
    ovf_next        = ovf;
    finish          = 1'b0;
    pend_we         = 1'b0;
    pend_view       = pending;
    res_valid       = accept && last_byte;
    res             = '0;
    ok              = 1'b0;

    if (accept) begin
      if (pos >= POS_W'(MAX_FILE_BYTES)) begin
        ovf_next = 1'b1;
      end else begin
        pos_next = pos + POS_W'(1);
        case (phase)
          PH_FILE: begin
            if (pos < POS_W'(rwhp_pkg::TAG_BYTES) || pos >= POS_W'(rwhp_pkg::HDR_BYTES)) begin
              tag_next = {tag[23:0], file_byte};
            end
            if (pos == POS_W'(rwhp_pkg::TAG_BYTES - 1)) begin
              tags_ok_next = (tag_next == rwhp_pkg::TAG_RIFF);
              tag_next     = '0;
            end
            if (pos == POS_W'(rwhp_pkg::FIRST_CHUNK - 1)) begin
              tags_ok_next = tags_ok && (tag_next == rwhp_pkg::TAG_WAVE);
              phase_next   = PH_HDR;
              left_next    = 32'(rwhp_pkg::HDR_BYTES);
              tag_next     = '0;
              size_next    = '0;
            end
          end
          PH_HDR: begin
            // tag bytes first, then the size little endian
            if (left > 32'(rwhp_pkg::TAG_BYTES)) begin
              tag_next = {tag[23:0], file_byte};
            end else begin
              size_next = {file_byte, size[31:8]};
            end
            left_next = left - 32'd1;
            if (left == 32'd1) begin
              body_start_next = pos_inc[18:0];
              left_next       = size_next;
              phase_next      = PH_BODY;
              fmt_cnt_next    = '0;
              finish          = (size_next == 32'd0);
            end
          end
          PH_BODY: begin
            if (!fmt_cnt[4]) begin
              pend_we                  = 1'b1;
              pend_view[fmt_cnt[3:0]]  = file_byte;
              fmt_cnt_next             = fmt_cnt + 5'd1;
            end
            left_next = left - 32'd1;
            finish    = (left == 32'd1);
          end
          PH_PAD: begin
            phase_next = PH_HDR;
            left_next  = 32'(rwhp_pkg::HDR_BYTES);
            tag_next   = '0;
            size_next  = '0;
          end
          default: begin
            phase_next = PH_HDR;
          end
        endcase

        if (finish) begin
          if (tag_next == rwhp_pkg::TAG_FMT && size_next >= 32'(rwhp_pkg::FMT_MIN)) begin
            kept_fmt0_next  = {pend_view[3], pend_view[2], pend_view[1], pend_view[0]};
            kept_fmt1_next  = {pend_view[15], pend_view[14], pend_view[13], pend_view[12]};
            kept_rates_next = {pend_view[11], pend_view[10], pend_view[9], pend_view[8],
                               pend_view[7], pend_view[6], pend_view[5], pend_view[4]};
          end else if (tag_next == rwhp_pkg::TAG_DATA) begin
            kept_doff_next = body_start_next;
            kept_dlen_next = size_next[18:0];
          end
          if (size_next[0]) begin
            phase_next = PH_PAD;
          end else begin
            phase_next = PH_HDR;
            left_next  = 32'(rwhp_pkg::HDR_BYTES);
            tag_next   = '0;
            size_next  = '0;
          end
        end
      end
    end

    ok = tags_ok_next && (pos_next >= POS_W'(rwhp_pkg::MIN_FILE));
    if (ok) begin
      res.format_tag    = kept_fmt0_next[15:0];
      res.channel_count = kept_fmt0_next[31:16];
      res.frame_size    = kept_fmt1_next[15:0];
      res.sample_bits   = kept_fmt1_next[31:16];
      res.sample_freq   = kept_rates_next[31:0];
      res.bytes_per_sec = kept_rates_next[63:32];
      res.data_offset   = kept_doff_next;
      res.data_length   = kept_dlen_next;
    end
    res.is_valid = ok && !ovf_next && (res.format_tag == 16'd1) &&
                   (res.channel_count == 16'd1 || res.channel_count == 16'd2) &&
                   (res.sample_freq != 32'd0) &&
                   (res.sample_bits == 16'd8 || res.sample_bits == 16'd16) &&
                   (res.data_length != 19'd0);

    // end of file: back to the reset state for the next one
    if (accept && last_byte) begin
      pos_next        = '0;
      tags_ok_next    = 1'b0;
      phase_next      = PH_FILE;
      tag_next        = '0;
      size_next       = '0;
      left_next       = '0;
      body_start_next = '0;
      fmt_cnt_next    = '0;
      kept_fmt0_next  = '0;
      kept_fmt1_next  = '0;
      kept_rates_next = '0;
      kept_doff_next  = '0;
      kept_dlen_next  = '0;
      ovf_next        = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      tags_ok    <= 1'b0;
      phase      <= PH_FILE;
      tag        <= '0;
      size       <= '0;
      left       <= '0;
      body_start <= '0;
      fmt_cnt    <= '0;
      kept_fmt0  <= '0;
      kept_fmt1  <= '0;
      kept_rates <= '0;
      kept_doff  <= '0;
      kept_dlen  <= '0;
      ovf        <= 1'b0;
    end else begin
      pos        <= pos_next;
      tags_ok    <= tags_ok_next;
      phase      <= phase_next;
      tag        <= tag_next;
      size       <= size_next;
      left       <= left_next;
      body_start <= body_start_next;
      fmt_cnt    <= fmt_cnt_next;
      kept_fmt0  <= kept_fmt0_next;
      kept_fmt1  <= kept_fmt1_next;
      kept_rates <= kept_rates_next;
      kept_doff  <= kept_doff_next;
      kept_dlen  <= kept_dlen_next;
      ovf        <= ovf_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_we) begin
      pending[fmt_cnt[3:0]] <= file_byte;
    end
  end

endmodule

`default_nettype wire
